// ===== hdl/wri_pkg.sv =====
// ----------------------------------------------------------------------------
// wri_pkg - shared types and constants of the window ruggedness index
// Field widths, register indexes, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package wri_pkg;

   // default sizes of the sample memory and the window
   localparam int DEF_MAX_WIDTH   = 256;
   localparam int DEF_MAX_HEIGHT  = 256;
   localparam int DEF_MAX_RADIUS  = 8;
   localparam int DEF_SAMPLE_BITS = 16;

   // fixed field widths
   localparam int COORD_BITS     = 8;
   localparam int HEIGHT_BITS    = 16;
   localparam int DIM_BITS       = 9;
   localparam int RADIUS_BITS    = 4;
   localparam int VALUE_BITS     = 21;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 9;

   localparam logic [DIM_BITS-1:0]    FRAME_WIDTH_RESET  = 9'd256;
   localparam logic [DIM_BITS-1:0]    FRAME_HEIGHT_RESET = 9'd256;
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET       = 4'd1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_WINDOW_RADIUS = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic {
      STATUS_OK      = 1'b0,
      STATUS_OUTSIDE = 1'b1
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTRE,
      ST_CWAIT,
      ST_SCAN,
      ST_DRAIN,
      ST_ROOT,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/wri_ram.sv =====
// ----------------------------------------------------------------------------
// wri_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wri_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/window_ruggedness_index.sv =====
// ----------------------------------------------------------------------------
// window_ruggedness_index - windowed ruggedness over a stored heightmap
// Holds one heightmap frame and answers ruggedness queries on it.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries items in: op 0 stores req_height at (req_col, req_row)
//   and gives no result; op 1 queries the pixel and gives one rsp_* item.
//   An item is taken when req_valid is high and req_stall is low.
//   csr_* writes frame_width (0), frame_height (1) and window_radius (2);
//   csr_ready is always high, write only while the block is idle.
// Flow:
//   A write goes into the memory as it is taken. A query in the frame
//   reads the centre, then N window samples (N after clipping, up to 289
//   at radius 8), then makes SUM/2 root steps (21 by default). The scan
//   is one read a cycle through the single memory read port; the root is
//   one bit a cycle through one add/compare unit. No item is taken until
//   the result is loaded; a query outside the frame goes straight to done.
// Reset:
//   Clears the sequencer, the valid flags and the registers to their
//   defaults; the sample memory keeps no reset and must be written first.
// Stall:
//   A result waits in the output register while rsp_stall is high; new
//   writes are still taken, a finished query holds until the slot frees.
// ----------------------------------------------------------------------------
module window_ruggedness_index import wri_pkg::*; #(
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   // item in
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_op,
   input  logic [COORD_BITS-1:0]     req_col,
   input  logic [COORD_BITS-1:0]     req_row,
   input  logic [HEIGHT_BITS-1:0]    req_height,
   // result item out
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [VALUE_BITS-1:0]     rsp_rugged_value,
   output logic [COORD_BITS-1:0]     rsp_query_col,
   output logic [COORD_BITS-1:0]     rsp_query_row,
   output logic                      rsp_status,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int SQ_BITS   = 2 * SAMPLE_BITS;
   localparam int SUM_BITS  = SQ_BITS + $clog2((2*MAX_RADIUS+1) * (2*MAX_RADIUS+1));
   localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
   localparam logic [SUM_BITS-1:0] BIT_START = SUM_BITS'(1) << (2 * (ROOT_BITS - 1));

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   state_type               state_ff, state_in;
   logic [DIM_BITS-1:0]     frame_width_ff, frame_width_in;
   logic [DIM_BITS-1:0]     frame_height_ff, frame_height_in;
   logic [RADIUS_BITS-1:0]  radius_ff, radius_in;
   logic                    p1_ff, p1_in;     // read data valid this cycle
   logic                    p2_ff, p2_in;     // square valid this cycle
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [COORD_BITS-1:0]   qcol_ff, qcol_in;
   logic [COORD_BITS-1:0]   qrow_ff, qrow_in;
   logic                    oob_ff, oob_in;
   logic [DIM_BITS-1:0]     c0_ff, c0_in;
   logic [DIM_BITS-1:0]     clast_ff, clast_in;
   logic [DIM_BITS-1:0]     rlast_ff, rlast_in;
   logic [DIM_BITS-1:0]     x_ff, x_in;
   logic [DIM_BITS-1:0]     y_ff, y_in;
   logic [SAMPLE_BITS-1:0]  centre_ff, centre_in;
   logic [SQ_BITS-1:0]      sq_ff, sq_in;
   logic [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [SUM_BITS-1:0]     res_ff, res_in;
   logic [SUM_BITS-1:0]     bit_ff, bit_in;
   logic [VALUE_BITS-1:0]   out_value_ff, out_value_in;
   logic [COORD_BITS-1:0]   out_col_ff, out_col_in;
   logic [COORD_BITS-1:0]   out_row_ff, out_row_in;
   logic                    out_status_ff, out_status_in;

   // ------------------------------------------------------------------------
   // combinational signals
   // ------------------------------------------------------------------------
   logic                    req_accept;
   logic                    query_start;
   logic                    rsp_load;
   logic                    scan_last;
   logic [DIM_BITS-1:0]     w_eff, h_eff;
   logic [DIM_BITS-1:0]     r_eff;
   logic [DIM_BITS-1:0]     col9, row9;
   logic [DIM_BITS-1:0]     chi, rhi;
   logic [DIM_BITS-1:0]     c0_q, r0_q, clast_q, rlast_q;
   logic                    oob_q;
   logic [DIM_BITS-1:0]     rd_x, rd_y;
   logic                    ram_wr_en, ram_rd_en;
   logic [ADDR_BITS-1:0]    ram_wr_addr, ram_rd_addr;
   logic [SAMPLE_BITS-1:0]  ram_wr_data, ram_rd_data;
   logic [SAMPLE_BITS-1:0]  diff;
   logic [SUM_BITS-1:0]     trial;
   logic                    trial_fits;

   // ------------------------------------------------------------------------
   // sample memory
   // ------------------------------------------------------------------------
   wri_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // frame and window geometry
   // ------------------------------------------------------------------------
   always_comb begin
      // saturate the registers into their usable ranges
      if (frame_width_ff == '0) begin
         w_eff = DIM_BITS'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w_eff = DIM_BITS'(MAX_WIDTH);
      end else begin
         w_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_eff = DIM_BITS'(1);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         h_eff = DIM_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = frame_height_ff;
      end
      if (32'(radius_ff) > MAX_RADIUS) begin
         r_eff = DIM_BITS'(MAX_RADIUS);
      end else begin
         r_eff = DIM_BITS'(radius_ff);
      end

      col9  = DIM_BITS'(req_col);
      row9  = DIM_BITS'(req_row);
      oob_q = (col9 >= w_eff) || (row9 >= h_eff);

      // clip the window at the frame borders, last edges inclusive
      chi     = col9 + r_eff;
      rhi     = row9 + r_eff;
      c0_q    = (col9 > r_eff) ? col9 - r_eff : '0;
      r0_q    = (row9 > r_eff) ? row9 - r_eff : '0;
      clast_q = (chi >= w_eff - 1'b1) ? w_eff - 1'b1 : chi;
      rlast_q = (rhi >= h_eff - 1'b1) ? h_eff - 1'b1 : rhi;
   end

   assign req_accept  = req_valid && !req_stall;
   assign query_start = req_accept && (req_op == OP_QUERY);
   assign scan_last   = (x_ff == clast_ff) && (y_ff == rlast_ff);
   assign rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // ------------------------------------------------------------------------
   // sequencer: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_start) begin
               state_in = oob_q ? ST_DONE : ST_CENTRE;
            end
         end
         ST_CENTRE: begin
            state_in = ST_CWAIT;
         end
         ST_CWAIT: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // leave once the last square has gone into the sum
            if (!p1_ff && !p2_ff) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (bit_ff[0]) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // sequencer: outputs
   // ------------------------------------------------------------------------
   always_comb begin
      req_stall = 1'b1;
      ram_rd_en = 1'b0;
      rd_x      = x_ff;
      rd_y      = y_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_CENTRE: begin
            ram_rd_en = 1'b1;
            rd_x      = DIM_BITS'(qcol_ff);
            rd_y      = DIM_BITS'(qrow_ff);
         end
         ST_SCAN: begin
            ram_rd_en = 1'b1;
         end
         ST_CWAIT, ST_DRAIN, ST_ROOT, ST_DONE: begin
            ram_rd_en = 1'b0;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // memory addressing: row-major over the physical width
   always_comb begin
      ram_wr_en   = req_accept && (req_op == OP_WRITE)
                    && (32'(req_col) < MAX_WIDTH) && (32'(req_row) < MAX_HEIGHT);
      ram_wr_addr = ADDR_BITS'(32'(req_row) * MAX_WIDTH + 32'(req_col));
      ram_wr_data = SAMPLE_BITS'(req_height);
      ram_rd_addr = ADDR_BITS'(32'(rd_y) * MAX_WIDTH + 32'(rd_x));
   end

   // ------------------------------------------------------------------------
   // datapath: difference, square, accumulate, root
   // ------------------------------------------------------------------------
   always_comb begin
      diff       = (centre_ff >= ram_rd_data) ? centre_ff - ram_rd_data
                                              : ram_rd_data - centre_ff;
      sq_in      = SQ_BITS'(diff) * SQ_BITS'(diff);
      p1_in      = (state_ff == ST_SCAN);
      p2_in      = p1_ff;
      trial      = res_ff + bit_ff;
      trial_fits = (sum_ff >= trial);
   end

   always_comb begin
      qcol_in   = qcol_ff;
      qrow_in   = qrow_ff;
      oob_in    = oob_ff;
      c0_in     = c0_ff;
      clast_in  = clast_ff;
      rlast_in  = rlast_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      centre_in = centre_ff;
      sum_in    = sum_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;

      // take a query's coordinates and window on acceptance
      if (query_start) begin
         qcol_in  = req_col;
         qrow_in  = req_row;
         oob_in   = oob_q;
         c0_in    = c0_q;
         clast_in = clast_q;
         rlast_in = rlast_q;
         x_in     = c0_q;
         y_in     = r0_q;
         sum_in   = '0;
         res_in   = '0;
         bit_in   = BIT_START;
      end

      if (state_ff == ST_CWAIT) begin
         centre_in = ram_rd_data;
      end

      // advance the window walk one sample a cycle
      if (state_ff == ST_SCAN) begin
         if (x_ff == clast_ff) begin
            x_in = c0_ff;
            y_in = y_ff + 1'b1;
         end else begin
            x_in = x_ff + 1'b1;
         end
      end

      if (p2_ff) begin
         sum_in = sum_ff + SUM_BITS'(sq_ff);
      end

      // one result bit a cycle; the sum register holds the remainder
      if (state_ff == ST_ROOT) begin
         if (trial_fits) begin
            sum_in = sum_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   // ------------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_value_in  = out_value_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      out_status_in = out_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         out_value_in  = oob_ff ? '0 : VALUE_BITS'(res_ff);
         out_col_in    = qcol_ff;
         out_row_in    = qrow_ff;
         out_status_in = oob_ff ? STATUS_OUTSIDE : STATUS_OK;
      end
   end

   // ------------------------------------------------------------------------
   // register writes
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      radius_in       = radius_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:   frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT:  frame_height_in = csr_wdata;
            CSR_WINDOW_RADIUS: radius_in       = csr_wdata[RADIUS_BITS-1:0];
            default: begin
               // drop writes beyond the register list
               radius_in = radius_ff;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // flip-flops
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         radius_ff       <= RADIUS_RESET;
         p1_ff           <= 1'b0;
         p2_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         radius_ff       <= radius_in;
         p1_ff           <= p1_in;
         p2_ff           <= p2_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qcol_ff       <= qcol_in;
      qrow_ff       <= qrow_in;
      oob_ff        <= oob_in;
      c0_ff         <= c0_in;
      clast_ff      <= clast_in;
      rlast_ff      <= rlast_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      centre_ff     <= centre_in;
      sq_ff         <= sq_in;
      sum_ff        <= sum_in;
      res_ff        <= res_in;
      bit_ff        <= bit_in;
      out_value_ff  <= out_value_in;
      out_col_ff    <= out_col_in;
      out_row_ff    <= out_row_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rugged_value = out_value_ff;
   assign rsp_query_col    = out_col_ff;
   assign rsp_query_row    = out_row_ff;
   assign rsp_status       = out_status_ff;

endmodule
